// ----- rtl/core/rnm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Renumbering map package
// Sizes, operation codes and the command/status bundles shared by the
// controller and the datapath of the renumbering map.
// ----------------------------------------------------------------------------
package rnm_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned NumW       = 32;

  localparam logic OpAssign = 1'b0;
  localparam logic OpLookup = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic start;   // latch a new item and restart the scan
    logic scan;    // advance the scan by one entry
    logic finish;  // load the result and insert if needed
  } rnm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic hit;        // the compared entry holds the key
    logic exhausted;  // every filled entry was compared without a hit
    logic out_free;   // the result register can take a beat this cycle
  } rnm_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/rnm_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Renumbering map input channel
// Valid/ready channel carrying one operation and one old number per beat.
// ----------------------------------------------------------------------------
interface rnm_in_if;

  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] old_number;

  modport source (output valid, output operation, output old_number, input ready);
  modport sink   (input valid, input operation, input old_number, output ready);

endinterface
`default_nettype wire

// ----- rtl/core/rnm_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Renumbering map output channel
// Valid/ready channel carrying the mapped number and its status flags.
// ----------------------------------------------------------------------------
interface rnm_out_if;

  logic        valid;
  logic        ready;
  logic [31:0] new_number;
  logic        result_flag;
  logic        was_present;
  logic        table_full;

  modport source (output valid, output new_number, output result_flag,
                  output was_present, output table_full, input ready);
  modport sink   (input valid, input new_number, input result_flag,
                  input was_present, input table_full, output ready);

endinterface
`default_nettype wire

// ----- rtl/core/rnm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Renumbering map controller
// Two-state sequencer: waits for an input beat, then drives the key scan
// until it hits or runs out of entries and the result register is free.
// ----------------------------------------------------------------------------
module rnm_ctrl import rnm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire rnm_sts_t sts_i,
  output rnm_cmd_t      cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic state_q, state_d;
  logic done;

  assign done = sts_i.hit | sts_i.exhausted;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        // The scan freezes once resolved so the hit stays put while the
        // receiver stalls.
        cmd_o.scan = ~done;
        if (done && sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rnm_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Renumbering map datapath
// Key memory, fill count, scan pipeline and result register. Entries fill
// in order and are never freed, so entry i always maps to id i + 1 and the
// fill count doubles as the last assigned id.
// ----------------------------------------------------------------------------
module rnm_dp import rnm_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rnm_cmd_t        cmd_i,
  output rnm_sts_t             sts_o,
  input  wire logic            operation_i,
  input  wire logic [NumW-1:0] old_number_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [NumW-1:0]      new_number_o,
  output logic                 result_flag_o,
  output logic                 was_present_o,
  output logic                 table_full_o
);

  logic [NumW-1:0] key_mem [TableDepth];

  logic            op_q;
  logic [NumW-1:0] key_q;
  logic [CntW-1:0] fill_q;
  logic [CntW-1:0] scan_idx_q;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic [NumW-1:0] rd_data_q;
  logic            out_valid_q;

  logic            rd_en;
  logic            hit;
  logic            exhausted;
  logic            full;
  logic            insert;
  logic [NumW-1:0] hit_id;
  logic [NumW-1:0] new_id;
  logic [NumW-1:0] res_num;
  logic            res_flag;

  assign rd_en     = cmd_i.scan && (scan_idx_q < fill_q);
  assign hit       = cmp_vld_q && (rd_data_q == key_q);
  assign exhausted = !cmp_vld_q && (scan_idx_q == fill_q);
  assign full      = (fill_q == CntW'(TableDepth));
  assign insert    = cmd_i.finish && !hit && (op_q == OpAssign) && !full;

  assign sts_o.hit       = hit;
  assign sts_o.exhausted = exhausted;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign hit_id = NumW'(cmp_idx_q) + NumW'(1);
  assign new_id = NumW'(fill_q) + NumW'(1);

  always_comb begin
    res_num  = key_q;
    res_flag = 1'b0;
    if (hit) begin
      res_num  = hit_id;
      res_flag = (op_q == OpLookup) ? 1'b1 : (hit_id != key_q);
    end else if ((op_q == OpAssign) && !full) begin
      res_num  = new_id;
      res_flag = (new_id != key_q);
    end
  end

  // Key memory: one read port for the scan, one write port for inserts.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= key_mem[scan_idx_q[IdxW-1:0]];
    end
    if (insert) begin
      key_mem[fill_q[IdxW-1:0]] <= key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= operation_i;
      key_q <= old_number_i;
    end
    if (rd_en) begin
      cmp_idx_q <= scan_idx_q[IdxW-1:0];
    end
    if (cmd_i.finish) begin
      new_number_o  <= res_num;
      result_flag_o <= res_flag;
      was_present_o <= hit;
      table_full_o  <= !hit && (op_q == OpAssign) && full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      scan_idx_q  <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        scan_idx_q <= '0;
        cmp_vld_q  <= 1'b0;
      end else if (cmd_i.scan) begin
        cmp_vld_q <= rd_en;
        if (rd_en) begin
          scan_idx_q <= scan_idx_q + CntW'(1);
        end
      end
      if (insert) begin
        fill_q <= fill_q + CntW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- rtl/core/number_renumbering_map_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Renumbering map core
// Maps old numbers to compact ids 1, 2, 3, ... in order of first assign.
//
// in_i carries one beat per item: operation (assign or lookup) and the old
// number. out_o returns one beat per item: the mapped number, the
// changed/found flag, whether the number was already stored and whether an
// assign was refused because all entries are taken.
// The keys sit in a memory with one registered read port that is scanned
// one entry per cycle. The result is loaded once the scan hits the key
// or has compared every filled entry without a hit, and only while the
// output register is free. The result beat is offered as soon as it is
// loaded. The next item is taken only after the result of the last one
// is loaded, so the scan of one item ends before the next is accepted.
// An insert is seen by the following item.
// The result sits in an output register; while the receiver stalls, the
// next item is accepted and scanned, and waits only to load its result.
// Reset empties the table and restarts the ids at 1; no clearing pass.
// ----------------------------------------------------------------------------
module number_renumbering_map_core import rnm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rnm_in_if.sink    in_i,
  rnm_out_if.source out_o
);

  rnm_cmd_t cmd;
  rnm_sts_t sts;

  rnm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rnm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (in_i.operation),
    .old_number_i  (in_i.old_number),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .new_number_o  (out_o.new_number),
    .result_flag_o (out_o.result_flag),
    .was_present_o (out_o.was_present),
    .table_full_o  (out_o.table_full)
  );

endmodule
`default_nettype wire

// ----- sim/tb_number_renumbering_map_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Renumbering map core testbench
// Drives assign and lookup beats into the map with random idle bursts and
// output stalls. A scoreboard keeps its own copy of the table and checks
// every returned beat field by field. The stimulus fills the table, then
// keeps pushing once no free entry is left.
// ----------------------------------------------------------------------------
module tb_number_renumbering_map_core;
  import rnm_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 80;

  typedef struct {
    logic [NumW-1:0] number;
    logic            flag;
    logic            present;
    logic            full;
  } map_result_t;

  typedef struct {
    logic            op;
    logic [NumW-1:0] key;
  } map_item_t;

  class remap_scoreboard;
    logic [NumW-1:0] stored_key[TableDepth];
    logic [NumW-1:0] stored_id[TableDepth];
    bit              slot_used[TableDepth];
    logic [NumW-1:0] id_counter;
    int unsigned     filled;
    int unsigned     mismatches;
    map_result_t     expected_maps[$];

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      id_counter  = '0;
      filled      = 0;
      mismatches  = 0;
    endfunction

    function void report_mismatch(string msg);
      mismatches++;
      $display("ERROR: %s", msg);
    endfunction

    // Works out the result of one accepted input beat and updates the table.
    function void note_item(logic op, logic [NumW-1:0] key);
      map_result_t r;
      int          hit_slot;
      int          free_slot;
      hit_slot  = -1;
      free_slot = -1;
      for (int i = 0; i < TableDepth; i++) begin
        if (slot_used[i] && stored_key[i] == key && hit_slot < 0) hit_slot = i;
        if (!slot_used[i] && free_slot < 0) free_slot = i;
      end
      r.number  = key;
      r.flag    = 1'b0;
      r.present = 1'b0;
      r.full    = 1'b0;
      if (hit_slot >= 0) begin
        r.present = 1'b1;
        r.number  = stored_id[hit_slot];
        r.flag    = (op == OpLookup) ? 1'b1 : (r.number != key);
      end else if (op == OpAssign) begin
        if (free_slot < 0) begin
          r.full = 1'b1;
        end else begin
          id_counter           = id_counter + 1;
          stored_key[free_slot] = key;
          stored_id[free_slot]  = id_counter;
          slot_used[free_slot]  = 1'b1;
          filled++;
          r.number = id_counter;
          r.flag   = (id_counter != key);
        end
      end
      expected_maps.insert(expected_maps.size(), r);
    endfunction

    function void check_result(map_result_t got);
      map_result_t want;
      if (expected_maps.size() == 0) begin
        report_mismatch($sformatf("result beat %h with no item outstanding", got.number));
        return;
      end
      want = expected_maps.pop_front();
      if (got.number !== want.number)
        report_mismatch($sformatf("new_number %h, expected %h", got.number, want.number));
      if (got.flag !== want.flag)
        report_mismatch($sformatf("result_flag %b, expected %b (number %h)",
                                  got.flag, want.flag, want.number));
      if (got.present !== want.present)
        report_mismatch($sformatf("was_present %b, expected %b (number %h)",
                                  got.present, want.present, want.number));
      if (got.full !== want.full)
        report_mismatch($sformatf("table_full %b, expected %b (number %h)",
                                  got.full, want.full, want.number));
    endfunction

    function int unsigned outstanding();
      return expected_maps.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   no_idle;
  int unsigned cycle_count = 0;
  logic [NumW-1:0] known_keys[$];

  remap_scoreboard board = new();

  rnm_in_if  in_if();
  rnm_out_if out_if();

  number_renumbering_map_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    map_result_t got;
    cycle_count <= cycle_count + 1;
    if (rst_ni && in_if.valid && in_if.ready)
      board.note_item(in_if.operation, in_if.old_number);
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.number  = out_if.new_number;
      got.flag    = out_if.result_flag;
      got.present = out_if.was_present;
      got.full    = out_if.table_full;
      board.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CycleLimit) begin
      board.report_mismatch("run did not complete within the cycle limit");
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stall bursts and ready stretches, steady at the end.
  initial begin : result_sink
    bit stall;
    int unsigned len;
    out_if.ready = 1'b0;
    forever begin
      if (no_idle) begin
        @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 2) == 0);
        len   = stall ? $urandom_range(1, 16) : $urandom_range(1, 40);
        repeat (len) begin
          @(negedge clk_i);
          out_if.ready <= !stall;
        end
      end
    end
  end

  function automatic logic [NumW-1:0] fresh_key();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 2 * TableDepth);
      1:       return {1'b1, 31'($urandom)};
      2:       return -$urandom_range(1, 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [NumW-1:0] pick_known();
    return known_keys[$urandom_range(0, known_keys.size() - 1)];
  endfunction

  task automatic send_item(input logic op, input logic [NumW-1:0] key);
    int unsigned gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      in_if.valid      <= 1'b0;
      in_if.old_number <= $urandom;
      in_if.operation  <= 1'($urandom_range(0, 1));
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid      <= 1'b1;
    in_if.operation  <= op;
    in_if.old_number <= key;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Lowers valid and holds off until every outstanding result has returned.
  task automatic pause_until_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count, input int unsigned new_pct,
                             input int unsigned steady_tail);
    int unsigned r;
    for (int unsigned n = 0; n < count; n++) begin
      if (n + steady_tail >= count) no_idle = 1'b1;
      r = $urandom_range(0, 99);
      if (r < new_pct || known_keys.size() == 0) begin
        known_keys.insert(known_keys.size(), fresh_key());
        send_item(OpAssign, known_keys[$]);
      end else if (r < new_pct + 35) begin
        send_item(OpAssign, pick_known());
      end else if (r < new_pct + 80) begin
        send_item(OpLookup, pick_known());
      end else begin
        send_item(OpLookup, fresh_key());
      end
    end
  endtask

  initial begin : stimulus
    map_item_t directed[$];
    rst_ni           = 1'b0;
    no_idle          = 1'b0;
    in_if.valid      = 1'b0;
    in_if.operation  = OpAssign;
    in_if.old_number = '0;

    // Empty-table lookup, extremes, a key equal to its own id, repeats and
    // lookups of absent numbers.
    directed = '{
      '{OpLookup, 32'h0000_0000}, '{OpAssign, 32'h0000_0001},
      '{OpAssign, 32'h8000_0000}, '{OpAssign, 32'h7FFF_FFFF},
      '{OpAssign, 32'hFFFF_FFFF}, '{OpAssign, 32'h0000_0000},
      '{OpAssign, 32'h0000_0006}, '{OpAssign, 32'h0000_0002},
      '{OpLookup, 32'h0000_0002}, '{OpLookup, 32'h0000_0007},
      '{OpAssign, 32'h8000_0000}, '{OpAssign, 32'h0000_0001},
      '{OpLookup, 32'h0000_0001}, '{OpLookup, 32'h7FFF_FFFF},
      '{OpLookup, 32'h5555_5555}, '{OpAssign, 32'hAAAA_AAAA},
      '{OpLookup, 32'hFFFF_FFFE}, '{OpAssign, 32'h0000_0000}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].key);
      if (directed[i].op == OpAssign) known_keys.insert(known_keys.size(), directed[i].key);
    end
    pause_until_drained();

    // Grow the table slowly so hits land on many fill levels.
    send_random(650, 8, 0);
    while (board.filled < TableDepth) begin
      known_keys.insert(known_keys.size(), fresh_key());
      send_item(OpAssign, known_keys[$]);
    end
    pause_until_drained();

    // Table is full: new numbers must be refused, stored ones still map.
    send_random(480, 25, 150);
    pause_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rnm_pkg.sv
rtl/core/rnm_in_if.sv
rtl/core/rnm_out_if.sv
rtl/core/rnm_ctrl.sv
rtl/core/rnm_dp.sv
rtl/core/number_renumbering_map_core.sv
sim/tb_number_renumbering_map_core.sv
